// ===== hw/rtl/sdts_pkg.sv =====
// Shared types and constants for the sorted-delay task scheduler.
`timescale 1ns / 1ps

package sdts_pkg;

    localparam int OP_W     = 3;
    localparam int HANDLE_W = 8;
    localparam int MS_W     = 24;
    localparam int TICKS_W  = 21;
    localparam int RUN_W    = 8;
    localparam int SLOT_W   = 5;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // One table entry as it sits in a cell.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TICKS_W-1:0]  ticks;
        logic [MS_W-1:0]     period;
        logic                once;
        logic [RUN_W-1:0]    run;
    } entry_t;

    // Commands broadcast from the sequencer to every cell.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_TICK,
        CMD_INSERT,   // cells with ticks > key or at/after fill shift up; first takes new
        CMD_DELETE,   // cells at index >= pos take the right neighbor
        CMD_SHIFT_IN  // live cells shift down by one, new entry enters the last live cell
    } cmd_e;

    typedef struct packed {
        cmd_e                cmd;
        logic [TICKS_W-1:0]  key;
        entry_t              new_entry;
    } cell_ctl_t;

    // Divide a 24-bit millisecond count by ten (reciprocal multiply).
    function automatic logic [TICKS_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [MS_W+25-1:0] prod;
        prod = {25'd0, ms} * 49'd26843546;   // ceil(2^28/10)
        return prod[28 +: TICKS_W];
    endfunction

endpackage

// ===== hw/rtl/sdts_cell.sv =====
// One table cell: holds an entry and exchanges it with its neighbors.
`timescale 1ns / 1ps

module sdts_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdts_pkg::cell_ctl_t   ctl,
    input  logic                  at_or_after_del,  // index >= delete position
    input  logic                  below_fill,       // index < entry count
    input  logic                  last_live,        // index == entry count - 1
    input  logic                  left_insert,      // left neighbor shifts on insert
    input  sdts_pkg::entry_t      left_entry,
    input  sdts_pkg::entry_t      right_entry,
    output sdts_pkg::entry_t      entry,
    output logic                  shift_out         // this cell moves up on insert
);

    sdts_pkg::entry_t entry_reg, entry_next;

    assign entry     = entry_reg;
    assign shift_out = !below_fill || (entry_reg.ticks > ctl.key);

    always_comb begin
        entry_next = entry_reg;
        case (ctl.cmd)
            sdts_pkg::CMD_TICK: begin
                if (entry_reg.ticks != '0)
                    entry_next.ticks = entry_reg.ticks - 1'b1;
                if ((entry_reg.ticks <= sdts_pkg::TICKS_W'(1)) &&
                    (entry_reg.run != sdts_pkg::RUN_MAX))
                    entry_next.run = entry_reg.run + 1'b1;
            end
            sdts_pkg::CMD_INSERT: begin
                if (shift_out)
                    entry_next = left_insert ? left_entry : ctl.new_entry;
            end
            sdts_pkg::CMD_DELETE: begin
                if (at_or_after_del)
                    entry_next = right_entry;
            end
            sdts_pkg::CMD_SHIFT_IN: begin
                if (last_live)
                    entry_next = ctl.new_entry;
                else if (below_fill)
                    entry_next = right_entry;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== hw/rtl/sorted_delay_task_scheduler.sv =====
// Top level of the sorted-delay task scheduler.
`timescale 1ns / 1ps

// Task table kept as a row of MAX_TASKS cells sorted by remaining delay in ticks.
// Commands arrive on the s_ stream (opcode clear/add/tick/dispatch/delete), results
// leave on the m_ stream with tlast on the final result of a command. One command
// is worked at a time. Clear and tick take effect on acceptance; add and delete
// pass through an insert or delete state, then the result transaction, since every
// cell shifts in parallel. Dispatch walks the live entries once around the cell
// chain, one per cycle: the entry in cell 0 leaves, a kept one re-enters at the end
// of the live region, a ready one is queued and the live region shrinks by one. The
// queued tasks are then reported in order, one per cycle unless the m_ side stalls or a
// reinsertion runs; each periodic one is reinserted in the cycle after its report.
module sorted_delay_task_scheduler #(
    parameter int MAX_TASKS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, low bit up: opcode[3], task_handle[8], delay_ms[24], period_ms[24],
    // one_shot[1], slot_index[5], zero pad[7]
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata, low bit up: result_kind[2], status[2], ready_handle[8], zero pad[4]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // input field unpack
    logic [2:0]  in_op;
    logic [7:0]  in_handle;
    logic [23:0] in_delay, in_period;
    logic        in_once;
    logic [4:0]  in_slot;
    assign in_op     = s_tdata[2:0];
    assign in_handle = s_tdata[10:3];
    assign in_delay  = s_tdata[34:11];
    assign in_period = s_tdata[58:35];
    assign in_once   = s_tdata[59];
    assign in_slot   = s_tdata[64:60];

    typedef enum logic [2:0] {
        S_IDLE, S_INSERT, S_DELETE, S_ROTATE, S_REQUEUE, S_OUT
    } state_e;

    state_e                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       step_reg;      // entries left to walk
    logic [5:0]             del_pos_reg;
    sdts_pkg::entry_t       pend_reg;      // entry to insert
    logic                   requeue_reg;   // insert belongs to dispatch
    logic                   final_reg;     // requeue is the last one
    // requeue FIFO of ready entries (one per cell position, read in order)
    logic [7:0]             rq_handle_reg [MAX_TASKS];
    logic [23:0]            rq_period_reg [MAX_TASKS];
    logic                   rq_once_reg   [MAX_TASKS];
    logic [CNT_W-1:0]       rq_n_reg, rq_rd_reg;
    // output register
    logic [15:0]            m_tdata_reg;
    logic                   m_tlast_reg, m_tvalid_reg;

    sdts_pkg::cell_ctl_t    ctl;
    sdts_pkg::entry_t       cells [MAX_TASKS];
    logic                   shifts [MAX_TASKS];
    sdts_pkg::entry_t       tail_in;

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // broadcast control
    always_comb begin
        ctl.cmd       = sdts_pkg::CMD_HOLD;
        ctl.key       = pend_reg.ticks;
        ctl.new_entry = pend_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready && in_op == sdts_pkg::OP_TICK)
                    ctl.cmd = sdts_pkg::CMD_TICK;
            S_INSERT:  ctl.cmd = sdts_pkg::CMD_INSERT;
            S_DELETE:  ctl.cmd = sdts_pkg::CMD_DELETE;
            S_ROTATE: begin
                // entry leaving cell 0 goes to the end of the live region
                ctl.cmd       = sdts_pkg::CMD_SHIFT_IN;
                ctl.new_entry = cells[0];
            end
            default: ;
        endcase
    end

    // top cell's right neighbor on delete (content past the fill is don't-care)
    always_comb begin
        tail_in = cells[0];
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            sdts_pkg::entry_t le, re;
            logic             li;
            if (g == 0) begin : g_l0
                assign le = cells[0];
                assign li = 1'b0;
            end else begin : g_ln
                assign le = cells[g-1];
                assign li = shifts[g-1];
            end
            if (g == MAX_TASKS - 1) begin : g_rl
                assign re = tail_in;
            end else begin : g_rn
                assign re = cells[g+1];
            end
            sdts_cell u_cell (
                .aclk            (aclk),
                .aresetn         (aresetn),
                .ctl             (ctl),
                .at_or_after_del (6'(g) >= del_pos_reg),
                .below_fill      (CNT_W'(g) < count_reg),
                .last_live       (CNT_W'(g + 1) == count_reg),
                .left_insert     (li),
                .left_entry      (le),
                .right_entry     (re),
                .entry           (cells[g]),
                .shift_out       (shifts[g])
            );
        end
    endgenerate

    logic [IDX_W-1:0] rq_idx;
    logic             rq_emit;
    assign rq_idx  = rq_rd_reg[IDX_W-1:0];
    // a queued dispatch result goes out this cycle
    assign rq_emit = (state_reg == S_OUT) && (rq_rd_reg != rq_n_reg) &&
                     (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
            rq_n_reg     <= '0;
            rq_rd_reg    <= '0;
            requeue_reg  <= 1'b0;
            final_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !rq_emit)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        case (in_op)
                            sdts_pkg::OP_CLEAR: count_reg <= '0;
                            sdts_pkg::OP_ADD: begin
                                pend_reg.handle <= in_handle;
                                pend_reg.ticks  <= sdts_pkg::ms_to_ticks(in_delay);
                                pend_reg.period <= in_period;
                                pend_reg.once   <= in_once;
                                pend_reg.run    <= '0;
                                requeue_reg     <= 1'b0;
                                if (count_reg >= CNT_W'(MAX_TASKS)) begin
                                    m_tdata_reg  <= {4'd0, 8'd0, sdts_pkg::ST_FULL,
                                                     sdts_pkg::KIND_ADD};
                                    m_tlast_reg  <= 1'b1;
                                    m_tvalid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_INSERT;
                                end
                            end
                            sdts_pkg::OP_DISPATCH: begin
                                step_reg  <= count_reg;
                                rq_n_reg  <= '0;
                                rq_rd_reg <= '0;
                                if (count_reg != '0) state_reg <= S_ROTATE;
                            end
                            sdts_pkg::OP_DELETE: begin
                                if ({2'b0, in_slot} >= 7'(count_reg)) begin
                                    m_tdata_reg  <= {4'd0, 8'd0, sdts_pkg::ST_RANGE,
                                                     sdts_pkg::KIND_DELETE};
                                    m_tlast_reg  <= 1'b1;
                                    m_tvalid_reg <= 1'b1;
                                end else begin
                                    del_pos_reg <= {1'b0, in_slot};
                                    state_reg   <= S_DELETE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_INSERT: begin
                    count_reg <= count_reg + 1'b1;
                    if (!requeue_reg) begin
                        m_tdata_reg  <= {4'd0, 8'd0, sdts_pkg::ST_OK,
                                         sdts_pkg::KIND_ADD};
                        m_tlast_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end else begin
                        state_reg <= final_reg ? S_IDLE : S_OUT;
                    end
                end
                S_DELETE: begin
                    count_reg    <= count_reg - 1'b1;
                    m_tdata_reg  <= {4'd0, 8'd0, sdts_pkg::ST_OK,
                                     sdts_pkg::KIND_DELETE};
                    m_tlast_reg  <= 1'b1;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_ROTATE: begin
                    // cell 0 leaves; a ready entry drops out of the live region
                    if (cells[0].run != '0) begin
                        rq_handle_reg[rq_n_reg[IDX_W-1:0]] <= cells[0].handle;
                        rq_period_reg[rq_n_reg[IDX_W-1:0]] <= cells[0].period;
                        rq_once_reg[rq_n_reg[IDX_W-1:0]]   <= cells[0].once;
                        rq_n_reg  <= rq_n_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == CNT_W'(1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (rq_rd_reg == rq_n_reg) begin
                        state_reg <= S_IDLE;
                    end else if (rq_emit) begin
                        m_tdata_reg  <= {4'd0, rq_handle_reg[rq_idx], sdts_pkg::ST_OK,
                                         sdts_pkg::KIND_DISPATCH};
                        m_tlast_reg  <= (rq_rd_reg + 1'b1 == rq_n_reg);
                        m_tvalid_reg <= 1'b1;
                        rq_rd_reg    <= rq_rd_reg + 1'b1;
                        final_reg    <= (rq_rd_reg + 1'b1 == rq_n_reg);
                        if (!rq_once_reg[rq_idx] && count_reg < CNT_W'(MAX_TASKS)) begin
                            pend_reg.handle <= rq_handle_reg[rq_idx];
                            pend_reg.ticks  <= sdts_pkg::ms_to_ticks(rq_period_reg[rq_idx]);
                            pend_reg.period <= rq_period_reg[rq_idx];
                            pend_reg.once   <= 1'b0;
                            pend_reg.run    <= '0;
                            requeue_reg     <= 1'b1;
                            state_reg       <= S_INSERT;
                        end else if (rq_rd_reg + 1'b1 == rq_n_reg) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sdts_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps

module sdts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tvalid,
    input logic        m_tready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad result kind");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd2 |-> m_tlast && m_tdata[15:4] == '0)
        else $error("status result malformed");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("command taken while result pending");

endmodule

bind sorted_delay_task_scheduler sdts_checker u_sdts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted-delay task scheduler.
`timescale 1ns / 1ps

module testbench;

    localparam int TASKS      = 32;
    localparam int IDLE_LIMIT = 5000;   // cycles without any transaction
    localparam int DRAIN_WAIT = 200;    // wait after the last expected result
    localparam int HOLD_LEN   = 400;    // long receiver hold-off

    typedef struct {
        logic [sdts_pkg::OP_W-1:0]     op;
        logic [sdts_pkg::HANDLE_W-1:0] handle;
        logic [sdts_pkg::MS_W-1:0]     delay_ms;
        logic [sdts_pkg::MS_W-1:0]     period_ms;
        logic                          once;
        logic [sdts_pkg::SLOT_W-1:0]   slot;
    } cmd_t;

    typedef struct {
        logic [sdts_pkg::KIND_W-1:0]   kind;
        logic [sdts_pkg::STAT_W-1:0]   status;
        logic [sdts_pkg::HANDLE_W-1:0] handle;
        logic                          last;
    } res_t;

    logic        aclk;
    logic        aresetn;
    logic [71:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;

    sorted_delay_task_scheduler #(.MAX_TASKS(TASKS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shadow copy of the task table.
    logic [sdts_pkg::HANDLE_W-1:0] tbl_handle [TASKS];
    logic [sdts_pkg::TICKS_W-1:0]  tbl_ticks  [TASKS];
    logic [sdts_pkg::MS_W-1:0]     tbl_period [TASKS];
    logic                          tbl_once   [TASKS];
    logic [sdts_pkg::RUN_W-1:0]    tbl_run    [TASKS];
    int                            tbl_used;

    cmd_t pending_cmds[$];
    res_t due_results[$];

    int n_errors    = 0;
    int n_cmds      = 0;
    int n_results   = 0;
    int n_dispatched = 0;
    int n_full      = 0;
    int n_range     = 0;
    int idle_cycles = 0;

    // Sorted insert: lands after every entry with equal or smaller delay.
    function automatic bit tbl_insert(logic [sdts_pkg::HANDLE_W-1:0] h,
                                      logic [sdts_pkg::TICKS_W-1:0] t,
                                      logic [sdts_pkg::MS_W-1:0] p, logic o);
        int pos;
        if (tbl_used >= TASKS) return 1'b0;
        pos = tbl_used;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_ticks[i] > t) begin
                pos = i;
                break;
            end
        end
        for (int i = tbl_used; i > pos; i--) begin
            tbl_handle[i] = tbl_handle[i-1];
            tbl_ticks[i]  = tbl_ticks[i-1];
            tbl_period[i] = tbl_period[i-1];
            tbl_once[i]   = tbl_once[i-1];
            tbl_run[i]    = tbl_run[i-1];
        end
        tbl_handle[pos] = h;
        tbl_ticks[pos]  = t;
        tbl_period[pos] = p;
        tbl_once[pos]   = o;
        tbl_run[pos]    = '0;
        tbl_used++;
        return 1'b1;
    endfunction

    function automatic void push_result(logic [sdts_pkg::KIND_W-1:0] k,
                                        logic [sdts_pkg::STAT_W-1:0] s,
                                        logic [sdts_pkg::HANDLE_W-1:0] h, logic l);
        res_t r;
        r.kind = k; r.status = s; r.handle = h; r.last = l;
        due_results.push_back(r);
    endfunction

    // Advance the shadow table by one command and queue what it produces.
    function automatic void sched_step(cmd_t c);
        logic [sdts_pkg::HANDLE_W-1:0] rdy_h [TASKS];
        logic [sdts_pkg::MS_W-1:0]     rdy_p [TASKS];
        logic                          rdy_o [TASKS];
        int nrdy;
        int keep;
        bit ok;
        nrdy = 0;
        keep = 0;
        case (c.op)
            sdts_pkg::OP_CLEAR: tbl_used = 0;
            sdts_pkg::OP_ADD: begin
                ok = tbl_insert(c.handle, sdts_pkg::TICKS_W'(c.delay_ms / 10),
                                c.period_ms, c.once);
                push_result(sdts_pkg::KIND_ADD, ok ? sdts_pkg::ST_OK : sdts_pkg::ST_FULL,
                            '0, 1'b1);
            end
            sdts_pkg::OP_TICK: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_ticks[i] != 0) tbl_ticks[i]--;
                    if (tbl_ticks[i] == 0 && tbl_run[i] != sdts_pkg::RUN_MAX) tbl_run[i]++;
                end
            end
            sdts_pkg::OP_DISPATCH: begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_run[i] != 0) begin
                        rdy_h[nrdy] = tbl_handle[i];
                        rdy_p[nrdy] = tbl_period[i];
                        rdy_o[nrdy] = tbl_once[i];
                        nrdy++;
                    end else begin
                        tbl_handle[keep] = tbl_handle[i];
                        tbl_ticks[keep]  = tbl_ticks[i];
                        tbl_period[keep] = tbl_period[i];
                        tbl_once[keep]   = tbl_once[i];
                        tbl_run[keep]    = tbl_run[i];
                        keep++;
                    end
                end
                tbl_used = keep;
                // ready tasks go out in table order; periodic ones are re-queued
                for (int i = 0; i < nrdy; i++) begin
                    push_result(sdts_pkg::KIND_DISPATCH, sdts_pkg::ST_OK, rdy_h[i],
                                i + 1 == nrdy);
                    if (!rdy_o[i])
                        ok = tbl_insert(rdy_h[i], sdts_pkg::TICKS_W'(rdy_p[i] / 10),
                                        rdy_p[i], 1'b0);
                end
            end
            sdts_pkg::OP_DELETE: begin
                if (c.slot >= tbl_used) begin
                    push_result(sdts_pkg::KIND_DELETE, sdts_pkg::ST_RANGE, '0, 1'b1);
                end else begin
                    for (int i = c.slot; i + 1 < tbl_used; i++) begin
                        tbl_handle[i] = tbl_handle[i+1];
                        tbl_ticks[i]  = tbl_ticks[i+1];
                        tbl_period[i] = tbl_period[i+1];
                        tbl_once[i]   = tbl_once[i+1];
                        tbl_run[i]    = tbl_run[i+1];
                    end
                    tbl_used--;
                    push_result(sdts_pkg::KIND_DELETE, sdts_pkg::ST_OK, '0, 1'b1);
                end
            end
            default: ;   // unused opcodes do nothing
        endcase
    endfunction

    function automatic void add_cmd(logic [sdts_pkg::OP_W-1:0] op,
                                    logic [sdts_pkg::HANDLE_W-1:0] h,
                                    logic [sdts_pkg::MS_W-1:0] d,
                                    logic [sdts_pkg::MS_W-1:0] p,
                                    logic o, logic [sdts_pkg::SLOT_W-1:0] s);
        cmd_t c;
        c.op = op; c.handle = h; c.delay_ms = d; c.period_ms = p; c.once = o; c.slot = s;
        pending_cmds.push_back(c);
    endfunction

    // Mostly short times so tasks come due; now and then the full 24-bit range.
    function automatic logic [sdts_pkg::MS_W-1:0] rand_ms();
        if ($urandom_range(0, 7) == 0) return sdts_pkg::MS_W'($urandom);
        return sdts_pkg::MS_W'($urandom_range(0, 60));
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of random length, random gaps in between.
    // A transaction stays offered until the block takes it.
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                sched_step(pending_cmds[0]);
                void'(pending_cmds.pop_front());
                n_cmds++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pending_cmds[0].slot, pending_cmds[0].once,
                             pending_cmds[0].period_ms, pending_cmds[0].delay_ms,
                             pending_cmds[0].handle, pending_cmds[0].op};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: receiver stall pattern plus one long hold-off, and the
    // field-by-field check against the oldest expected result.
    // ---------------------------------------------------------------
    int  cyc       = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    res_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            cyc++;
            if (m_tvalid && m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d status %0d handle %0d last %0d",
                           m_tdata[1:0], m_tdata[3:2], m_tdata[11:4], m_tlast);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[1:0] !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, m_tdata[1:0]);
                        n_errors++;
                    end
                    if (m_tdata[3:2] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[3:2]);
                        n_errors++;
                    end
                    if (m_tdata[11:4] !== want.handle) begin
                        $error("ready_handle: expected %0d, got %0d",
                               want.handle, m_tdata[11:4]);
                        n_errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        n_errors++;
                    end
                    if (want.kind == sdts_pkg::KIND_DISPATCH) n_dispatched++;
                    if (want.status == sdts_pkg::ST_FULL) n_full++;
                    if (want.status == sdts_pkg::ST_RANGE) n_range++;
                end
            end
            // long hold-off once the run is well under way: input side backs up
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && n_cmds >= 120) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end else begin
                case ((cyc / 600) % 3)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int r;
        aresetn = 1'b0;
        tbl_used = 0;

        // directed: field extremes, every opcode, corner cases
        add_cmd(sdts_pkg::OP_DISPATCH, 8'd0, '0, '0, 1'b0, 5'd0);     // nothing ready
        add_cmd(sdts_pkg::OP_DELETE, 8'd0, '0, '0, 1'b0, 5'd31);      // delete past end
        add_cmd(sdts_pkg::OP_ADD, 8'd0, 24'd0, 24'd0, 1'b0, 5'd0);    // every-tick task
        add_cmd(sdts_pkg::OP_ADD, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 5'd31);
        add_cmd(sdts_pkg::OP_ADD, 8'd17, 24'd9, 24'd10, 1'b1, 5'd0);  // rounds down to 0
        add_cmd(sdts_pkg::OP_ADD, 8'd18, 24'd10, 24'd20, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_ADD, 8'd19, 24'd10, 24'd19, 1'b0, 5'd0); // equal delay after
        add_cmd(sdts_pkg::OP_TICK, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DISPATCH, 8'd0, '0, '0, 1'b0, 5'd0);     // several ready
        add_cmd(3'd5, 8'hAA, 24'h555555, 24'hAAAAAA, 1'b1, 5'd21);
        add_cmd(3'd6, 8'h55, '0, '0, 1'b0, 5'd10);
        add_cmd(3'd7, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 5'd31);
        add_cmd(sdts_pkg::OP_TICK, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_TICK, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DELETE, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DISPATCH, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_CLEAR, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DELETE, 8'd0, '0, '0, 1'b0, 5'd0);       // empty table

        // fill to capacity, one add too many, then trim from both ends
        for (int i = 0; i <= TASKS; i++)
            add_cmd(sdts_pkg::OP_ADD, 8'(i + 100),
                    sdts_pkg::MS_W'($urandom_range(0, 400)),
                    sdts_pkg::MS_W'($urandom_range(0, 300)), 1'($urandom), 5'd0);
        add_cmd(sdts_pkg::OP_DELETE, 8'd0, '0, '0, 1'b0, 5'd31);
        add_cmd(sdts_pkg::OP_DELETE, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_TICK, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DISPATCH, 8'd0, '0, '0, 1'b0, 5'd0);

        // random mix weighted toward adds, ticks and dispatches
        for (int i = 0; i < 100; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                add_cmd(sdts_pkg::OP_ADD, 8'($urandom), rand_ms(), rand_ms(),
                        ($urandom_range(0, 3) == 0), 5'($urandom));
            else if (r < 65)
                add_cmd(sdts_pkg::OP_TICK, 8'($urandom), sdts_pkg::MS_W'($urandom),
                        sdts_pkg::MS_W'($urandom), 1'($urandom), 5'($urandom));
            else if (r < 80)
                add_cmd(sdts_pkg::OP_DISPATCH, 8'($urandom), sdts_pkg::MS_W'($urandom),
                        sdts_pkg::MS_W'($urandom), 1'($urandom), 5'($urandom));
            else if (r < 92)
                add_cmd(sdts_pkg::OP_DELETE, 8'($urandom), sdts_pkg::MS_W'($urandom),
                        sdts_pkg::MS_W'($urandom), 1'($urandom),
                        5'($urandom_range(0, 31)));
            else if (r < 95)
                add_cmd(sdts_pkg::OP_CLEAR, 8'($urandom), sdts_pkg::MS_W'($urandom),
                        sdts_pkg::MS_W'($urandom), 1'($urandom), 5'($urandom));
            else
                add_cmd(3'($urandom_range(5, 7)), 8'($urandom), sdts_pkg::MS_W'($urandom),
                        sdts_pkg::MS_W'($urandom), 1'($urandom), 5'($urandom));
        end
        add_cmd(sdts_pkg::OP_TICK, 8'd0, '0, '0, 1'b0, 5'd0);
        add_cmd(sdts_pkg::OP_DISPATCH, 8'd0, '0, '0, 1'b0, 5'd0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            n_errors++;
        end

        $display("Run: %0d commands, %0d results (%0d dispatched tasks).",
                 n_cmds, n_results, n_dispatched);
        $display("Covered table-full adds: %0d, out-of-range deletes: %0d, errors: %0d.",
                 n_full, n_range, n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
